// ----- design/sha1_hash_engine_top_macros.svh -----
// assertion macros shared by the sha1 engine files
`ifndef SHA1_HASH_ENGINE_TOP_MACROS_SVH
`define SHA1_HASH_ENGINE_TOP_MACROS_SVH

// property that must hold whenever reset is released
`define SHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// implication checked in the following cycle
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sha1_pkg.sv -----
// shared types, constants and round functions for the sha1 engine
`default_nettype none
package sha1_pkg;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_POS     = 56;
    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam int unsigned FIFO_DEPTH  = 4;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } cmd_t;

    function automatic logic [31:0] round_f(input logic [6:0] rnd,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] r;
        if (rnd < 7'd20) r = (b & c) | (~b & d);
        else if (rnd < 7'd40) r = b ^ c ^ d;
        else if (rnd < 7'd60) r = (b & c) | (b & d) | (c & d);
        else r = b ^ c ^ d;
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] r;
        if (rnd < 7'd20) r = 32'h5A827999;
        else if (rnd < 7'd40) r = 32'h6ED9EBA1;
        else if (rnd < 7'd60) r = 32'h8F1BBCDC;
        else r = 32'hCA62C1D6;
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- design/sha1_hash_engine_top.sv -----
// top level of the sha1 hash engine
// usage:
//   s_axis carries one command word per transfer: tuser = action
//   (0 absorbs the byte in tdata, 1 finishes the message).
//   m_axis returns the five digest words H0..H4 after a finish;
//   tuser holds the word index, tlast marks the fifth word.
// queue and compression:
//   a four-word command queue decouples the input from the back end.
//   the back end absorbs a byte while idle; the 64th byte of a block
//   starts the 80 rounds, one per cycle, then the chain add, and no
//   new command is taken from the queue until both are done.
//   a finish writes the pad mark and the length and compresses before
//   the first digest word, with an extra block if the padding needs one.
// reset:
//   aresetn low loads the standard initial chain values, clears the
//   block buffer, length count and queue.
// stalls:
//   while m_axis_tready is low the digest word holds; the queue keeps
//   accepting bytes until it fills, then s_axis_tready drops.
`default_nettype none
module sha1_hash_engine_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte
    input  wire         s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    import sha1_pkg::*;

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;

    // pack the incoming word for the queue
    assign in_cmd.action    = s_axis_tuser;
    assign in_cmd.data_byte = s_axis_tdata;

    sha1_cmd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    // back end holds digest word stable until taken
    sha1_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .m_word(m_axis_tdata), .m_index(m_axis_tuser), .m_last(m_axis_tlast)
    );
endmodule
`default_nettype wire

// ----- design/sha1_cmd_fifo.sv -----
// front end: accepts words and queues them for the compression back end
`default_nettype none
module sha1_cmd_fifo (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    output logic               in_ready,
    input  sha1_pkg::cmd_t     in_cmd,
    output logic               out_valid,
    input  wire                out_ready,
    output sha1_pkg::cmd_t     out_cmd
);
    import sha1_pkg::*;
    `include "sha1_hash_engine_top_macros.svh"

    localparam int unsigned AW = $clog2(FIFO_DEPTH);
    cmd_t mem [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg, count_next;
    logic push, pop;

    assign in_ready  = (count_reg != (AW+1)'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `SHA_ASSERT(a_fifo_bound, count_reg <= (AW+1)'(FIFO_DEPTH), "fifo count overflow")
    `SHA_ASSERT_NEXT(a_fifo_push, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "fifo push lost")
    `SHA_ASSERT_NEXT(a_fifo_pop, pop && !push, count_reg == $past(count_reg) - 1'b1,
        "fifo pop lost")
endmodule
`default_nettype wire

// ----- design/sha1_core.sv -----
// back end: block buffer, padding sequencer, 80-round compression, digest output
`default_nettype none
module sha1_core (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cmd_valid,
    output logic               cmd_ready,
    input  sha1_pkg::cmd_t     cmd,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [31:0]        m_word,
    output logic [2:0]         m_index,
    output logic               m_last
);
    import sha1_pkg::*;
    `include "sha1_hash_engine_top_macros.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;  // write 0x80, maybe compress
    localparam logic [2:0] ST_LEN  = 3'd2;  // write length then compress
    localparam logic [2:0] ST_RND  = 3'd3;  // running rounds
    localparam logic [2:0] ST_ADD  = 3'd4;  // fold into chain
    localparam logic [2:0] ST_OUT  = 3'd5;  // emit digest

    logic [2:0]  state_reg;
    logic        fin_reg;     // compression belongs to a finish
    logic        lenpend_reg; // length block still owed after this compression
    logic [31:0] wbuf_reg [16];
    logic [6:0]  fill_reg;
    logic [63:0] blen_reg;
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  oidx_reg;

    logic [31:0] w_cur, w_new, t_val;
    assign w_cur = wbuf_reg[0];
    assign w_new = {wbuf_reg[13] ^ wbuf_reg[8] ^ wbuf_reg[2] ^ wbuf_reg[0]} << 1
                 | {wbuf_reg[13] ^ wbuf_reg[8] ^ wbuf_reg[2] ^ wbuf_reg[0]} >> 31;
    assign t_val = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
                 + e_reg + round_k(rnd_reg) + w_cur;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_word  = h_reg[oidx_reg];
    assign m_index = oidx_reg;
    assign m_last  = (oidx_reg == 3'd4);

    logic [3:0] wi;
    logic [1:0] bi;
    assign wi = fill_reg[5:2];
    assign bi = fill_reg[1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            blen_reg <= '0;
            fin_reg <= 1'b0;
            lenpend_reg <= 1'b0;
            rnd_reg <= '0;
            oidx_reg <= '0;
            for (int i = 0; i < 16; i++) wbuf_reg[i] <= '0;
            h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT; h_reg[2] <= H2_INIT;
            h_reg[3] <= H3_INIT; h_reg[4] <= H4_INIT;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        if (cmd.action == ACT_ABSORB) begin
                            wbuf_reg[wi][8*(3-bi) +: 8] <= cmd.data_byte;
                            blen_reg <= blen_reg + 64'd8;
                            if (fill_reg == 7'(BLOCK_BYTES - 1)) begin
                                fill_reg <= '0;
                                fin_reg <= 1'b0;
                                lenpend_reg <= 1'b0;
                                rnd_reg <= '0;
                                a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                                d_reg <= h_reg[3]; e_reg <= h_reg[4];
                                state_reg <= ST_RND;
                            end else begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                        end else begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    wbuf_reg[wi][8*(3-bi) +: 8] <= PAD_MARK;
                    if (fill_reg >= 7'(LEN_POS)) begin
                        fill_reg <= '0;
                        fin_reg <= 1'b0;
                        lenpend_reg <= 1'b1;
                        rnd_reg <= '0;
                        a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                        d_reg <= h_reg[3]; e_reg <= h_reg[4];
                        state_reg <= ST_RND;
                    end else begin
                        state_reg <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    wbuf_reg[14] <= blen_reg[63:32];
                    wbuf_reg[15] <= blen_reg[31:0];
                    fill_reg <= '0;
                    fin_reg <= 1'b1;
                    lenpend_reg <= 1'b0;
                    rnd_reg <= '0;
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                    state_reg <= ST_RND;
                end
                ST_RND: begin
                    // message schedule kept as a 16-word sliding window
                    for (int i = 0; i < 15; i++) wbuf_reg[i] <= wbuf_reg[i+1];
                    wbuf_reg[15] <= w_new;
                    e_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    b_reg <= a_reg;
                    a_reg <= t_val;
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 7'd79) state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    for (int i = 0; i < 16; i++) wbuf_reg[i] <= '0;
                    oidx_reg <= '0;
                    if (fin_reg) state_reg <= ST_OUT;
                    else if (lenpend_reg) state_reg <= ST_LEN;
                    else state_reg <= ST_IDLE;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (oidx_reg == 3'd4) begin
                            h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT; h_reg[2] <= H2_INIT;
                            h_reg[3] <= H3_INIT; h_reg[4] <= H4_INIT;
                            blen_reg <= '0;
                            fin_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end else begin
                            oidx_reg <= oidx_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `SHA_ASSERT(a_fill_range, fill_reg < 7'(BLOCK_BYTES), "fill count out of range")
    `SHA_ASSERT(a_out_idx, !m_valid || oidx_reg <= 3'd4, "digest index out of range")
    `SHA_ASSERT_NEXT(a_last_done, m_valid && m_ready && m_last, state_reg == ST_IDLE,
        "engine did not return to idle after digest")
endmodule
`default_nettype wire
